[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/lrbf_pkg.sv]
// ---------------------------------------------------------------------------
// lrbf_pkg
// Shared constants, codes and types of the log record block fragmenter.
// ---------------------------------------------------------------------------
package lrbf_pkg;

  // Block and record geometry
  localparam int unsigned BlockSize      = 32768;
  localparam int unsigned MaxRecordBytes = 1048576;
  localparam int unsigned MaxResults     = 34;

  // Field widths
  localparam int unsigned LenW    = 21;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned PadW    = 4;
  localparam int unsigned TypeW   = 4;
  localparam int unsigned FragW   = 15;
  localparam int unsigned HdrW    = 4;
  localparam int unsigned LogNumW = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  // Derived widths
  localparam int unsigned OffW = $clog2(BlockSize + 1);
  localparam int unsigned CmpW = (LenW > OffW) ? LenW : OffW;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  // Header sizes
  localparam logic [HdrW-1:0] LegacyHdr  = HdrW'(7);
  localparam logic [HdrW-1:0] RecycleHdr = HdrW'(11);

  // Fragment type codes
  localparam logic [TypeW-1:0] TypeFull    = TypeW'(1);
  localparam logic [TypeW-1:0] TypeFirst   = TypeW'(2);
  localparam logic [TypeW-1:0] TypeMiddle  = TypeW'(3);
  localparam logic [TypeW-1:0] TypeLast    = TypeW'(4);
  localparam logic [TypeW-1:0] RecycleBase = TypeW'(4);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRecycleMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLogNumber   = CfgIdxW'(1);

  // Request to the fragment unit
  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [LenW-1:0] left;
    logic [HdrW-1:0] hdr;
  } frag_req_t;

  // Answer from the fragment unit
  typedef struct packed {
    logic [PadW-1:0]  pad;
    logic [FragW-1:0] frag_len;
    logic [OffW-1:0]  offset_next;
    logic [LenW-1:0]  left_next;
    logic             done;
  } frag_rsp_t;

endpackage

[hdl/lrbf_if.sv]
// ---------------------------------------------------------------------------
// lrbf_if
// Valid/ready channels: record input, fragment output, register writes.
// ---------------------------------------------------------------------------
interface lrbf_rec_if import lrbf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] record_length;
  logic [CrcW-1:0] record_crc;

  modport source (output valid, record_length, record_crc, input ready);
  modport sink   (input valid, record_length, record_crc, output ready);
endinterface

interface lrbf_frag_if import lrbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PadW-1:0]    pad_bytes;
  logic [TypeW-1:0]   fragment_type;
  logic [FragW-1:0]   payload_bytes;
  logic [HdrW-1:0]    header_length;
  logic [CrcW-1:0]    header_crc;
  logic [LogNumW-1:0] header_log_number;
  logic               last_fragment;

  modport source (output valid, pad_bytes, fragment_type, payload_bytes,
                  header_length, header_crc, header_log_number, last_fragment,
                  input ready);
  modport sink   (input valid, pad_bytes, fragment_type, payload_bytes,
                  header_length, header_crc, header_log_number, last_fragment,
                  output ready);
endinterface

interface lrbf_cfg_if import lrbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/lrbf_frag_unit.sv]
// ---------------------------------------------------------------------------
// lrbf_frag_unit
// Shared per-fragment arithmetic: tail padding, room left in the block,
// fragment size and the next block offset. Used once per fragment.
// ---------------------------------------------------------------------------
module lrbf_frag_unit import lrbf_pkg::*; (
  input  frag_req_t req_i,
  output frag_rsp_t rsp_o
);

  logic [OffW-1:0] leftover;
  logic            short_tail;
  logic [OffW-1:0] off_eff;
  logic [OffW-1:0] avail;
  logic [CmpW-1:0] avail_ext;
  logic [CmpW-1:0] left_ext;
  logic [CmpW-1:0] frag;

  // Bytes remaining in the current block, and whether a header fits
  assign leftover   = OffW'(BlockSize) - req_i.offset;
  assign short_tail = leftover < OffW'(req_i.hdr);
  assign off_eff    = short_tail ? '0 : req_i.offset;

  // Payload room after the header
  assign avail     = short_tail ? OffW'(BlockSize) - OffW'(req_i.hdr)
                                : leftover - OffW'(req_i.hdr);
  assign avail_ext = CmpW'(avail);
  assign left_ext  = CmpW'(req_i.left);
  assign frag      = (left_ext < avail_ext) ? left_ext : avail_ext;

  // Results
  always_comb begin
    rsp_o.pad         = short_tail ? leftover[PadW-1:0] : '0;
    rsp_o.frag_len    = frag[FragW-1:0];
    rsp_o.offset_next = off_eff + OffW'(req_i.hdr) + frag[OffW-1:0];
    rsp_o.left_next   = req_i.left - frag[LenW-1:0];
    rsp_o.done        = (left_ext == frag);
  end

endmodule

[hdl/log_record_block_fragmenter.sv]
// ---------------------------------------------------------------------------
// log_record_block_fragmenter
// Splits a log record (length, CRC) into block-aligned fragments.
// The first fragment is registered after the record transfer, once the
// sequencer is in S_FRAG. Records are taken only in S_IDLE; one fragment per
// cycle from the shared fragment unit while the output is free.
// Reset: block offset 0, legacy mode, log number 0, output empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module log_record_block_fragmenter import lrbf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrbf_cfg_if.sink           cfg_i,
  lrbf_rec_if.sink           rec_i,
  lrbf_frag_if.source        frag_o
);

  typedef enum logic {
    S_IDLE,
    S_FRAG
  } state_e;

  state_e             state_q, state_d;
  logic               recycle_q;
  logic [LogNumW-1:0] lognum_q;
  logic [OffW-1:0]    offset_q;
  logic [LenW-1:0]    left_q;
  logic [CrcW-1:0]    crc_q;
  logic [CntW-1:0]    count_q;
  logic               out_valid_q;
  logic [PadW-1:0]    pad_q;
  logic [TypeW-1:0]   type_q;
  logic [FragW-1:0]   frag_q;
  logic [HdrW-1:0]    hdr_q;
  logic [CrcW-1:0]    ocrc_q;
  logic [LogNumW-1:0] olog_q;
  logic               last_q;

  logic               rec_xfer;
  logic               slot_free;
  logic               step;
  logic [HdrW-1:0]    hdr_cur;
  logic [LenW-1:0]    len_sat;
  logic               cap_hit;
  logic               frag_end;
  logic [TypeW-1:0]   type_code;
  frag_req_t          req;
  frag_rsp_t          rsp;

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign rec_i.ready = (state_q == S_IDLE);
  assign rec_xfer    = rec_i.valid && rec_i.ready;
  assign slot_free   = !out_valid_q || frag_o.ready;
  assign step        = (state_q == S_FRAG) && slot_free;

  // Record length saturation
  assign len_sat = (rec_i.record_length > LenW'(MaxRecordBytes)) ?
                   LenW'(MaxRecordBytes) : rec_i.record_length;

  // Fragment unit request
  assign hdr_cur    = recycle_q ? RecycleHdr : LegacyHdr;
  assign req.offset = offset_q;
  assign req.left   = left_q;
  assign req.hdr    = hdr_cur;

  lrbf_frag_unit u_frag (
    .req_i (req),
    .rsp_o (rsp)
  );

  // Fragment type and end of record
  assign cap_hit  = (count_q == CntW'(MaxResults - 1));
  assign frag_end = rsp.done || cap_hit;

  always_comb begin
    if (count_q == '0) begin
      type_code = rsp.done ? TypeFull : TypeFirst;
    end else begin
      type_code = rsp.done ? TypeLast : TypeMiddle;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (rec_xfer) state_d = S_FRAG;
      end
      S_FRAG: begin
        if (step && frag_end) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      recycle_q   <= 1'b0;
      lognum_q    <= '0;
      offset_q    <= '0;
      left_q      <= '0;
      crc_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pad_q       <= '0;
      type_q      <= '0;
      frag_q      <= '0;
      hdr_q       <= '0;
      ocrc_q      <= '0;
      olog_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CfgRecycleMode: recycle_q <= cfg_i.data[0];
          CfgLogNumber:   lognum_q  <= cfg_i.data[LogNumW-1:0];
          default: ;
        endcase
      end

      // record load
      if (rec_xfer) begin
        left_q  <= len_sat;
        crc_q   <= rec_i.record_crc;
        count_q <= '0;
      end

      // one fragment per step
      if (step) begin
        offset_q    <= rsp.offset_next;
        left_q      <= rsp.left_next;
        count_q     <= count_q + CntW'(1);
        out_valid_q <= 1'b1;
        pad_q       <= rsp.pad;
        type_q      <= type_code + (recycle_q ? RecycleBase : '0);
        frag_q      <= rsp.frag_len;
        hdr_q       <= hdr_cur;
        ocrc_q      <= crc_q;
        olog_q      <= recycle_q ? lognum_q : '0;
        last_q      <= frag_end;
      end else if (frag_o.valid && frag_o.ready) begin
        // output slot drains
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output channel
  assign frag_o.valid             = out_valid_q;
  assign frag_o.pad_bytes         = pad_q;
  assign frag_o.fragment_type     = type_q;
  assign frag_o.payload_bytes     = frag_q;
  assign frag_o.header_length     = hdr_q;
  assign frag_o.header_crc        = ocrc_q;
  assign frag_o.header_log_number = olog_q;
  assign frag_o.last_fragment     = last_q;

  // Checks
  `ASSERT_ALWAYS(a_offset_in_block, offset_q <= OffW'(BlockSize))
  `ASSERT_ALWAYS(a_pad_below_hdr, !out_valid_q || pad_q < hdr_q)
  `ASSERT_ALWAYS(a_mid_record_left, !(state_q == S_FRAG && count_q != '0) || left_q != '0)
  `ASSERT_NEXT(a_accept_starts, rec_xfer, state_q == S_FRAG && count_q == '0)

endmodule

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the log record block fragmenter. A short table of
// directed records and register writes comes first: empty and maximum-size
// records, short block tails, a header size change on a short tail, and
// writes to unused register indexes. Random records follow in phases with
// different register settings. Every fragment is compared field by field
// with an in-bench model of the block layout.
// ---------------------------------------------------------------------------
module tb import lrbf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned PhaseItems = 75;

  // Register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgTopIdx   = '1;

  typedef enum logic {RowRecord, RowConfig} row_kind_e;

  // One fragment as seen on the output channel
  typedef struct {
    logic [PadW-1:0]    pad;
    logic [TypeW-1:0]   ftype;
    logic [FragW-1:0]   flen;
    logic [HdrW-1:0]    hdr;
    logic [CrcW-1:0]    crc;
    logic [LogNumW-1:0] lognum;
    logic               last;
  } frag_t;

  // Directed step: a record or a register write, with an optional
  // hand-written single-fragment result
  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [LenW-1:0]    len;
    logic [CrcW-1:0]    word;
    bit                 typed;
    logic [PadW-1:0]    pad;
    logic [TypeW-1:0]   ftype;
    logic [FragW-1:0]   flen;
    logic [HdrW-1:0]    hdr;
    logic [LogNumW-1:0] lognum;
  } row_t;

  localparam int unsigned DirRows = 23;

  logic clk_i;
  logic rst_ni;

  lrbf_rec_if  rec_bus ();
  lrbf_cfg_if  cfg_bus ();
  lrbf_frag_if frag_bus ();

  log_record_block_fragmenter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .rec_i  (rec_bus),
    .frag_o (frag_bus)
  );

  // Layout model state
  int unsigned blk_offset;
  bit          cfg_recycle;
  logic [31:0] cfg_lognum;

  frag_t       frag_expect[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          src_burst;
  bit          sink_burst;

  row_t dir_table [DirRows];

  // Clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Lay one record out into fragments and queue the results
  function automatic void layout_record(logic [LenW-1:0] len, logic [CrcW-1:0] crc);
    int unsigned left, hdr, leftover, pad, avail, frag, count;
    bit          first, done;
    frag_t       f;
    left = len;
    if (left > MaxRecordBytes) left = MaxRecordBytes;
    hdr = cfg_recycle ? RecycleHdr : LegacyHdr;
    if (blk_offset > BlockSize) blk_offset = BlockSize;
    first = 1'b1;
    count = 0;
    do begin
      leftover = BlockSize - blk_offset;
      pad = 0;
      // short tail: pad it out and start a new block
      if (leftover < hdr) begin
        pad = leftover;
        blk_offset = 0;
      end
      avail = BlockSize - blk_offset - hdr;
      frag = (left < avail) ? left : avail;
      done = (left == frag);
      if (first && done) f.ftype = TypeFull;
      else if (first) f.ftype = TypeFirst;
      else if (done) f.ftype = TypeLast;
      else f.ftype = TypeMiddle;
      if (cfg_recycle) f.ftype = f.ftype + RecycleBase;
      left = left - frag;
      blk_offset = blk_offset + hdr + frag;
      first = 1'b0;
      count++;
      // fragment cap: the tail of the payload is dropped
      if (count >= MaxResults) done = 1'b1;
      f.pad    = pad[PadW-1:0];
      f.flen   = frag[FragW-1:0];
      f.hdr    = hdr[HdrW-1:0];
      f.crc    = crc;
      f.lognum = cfg_recycle ? cfg_lognum : '0;
      f.last   = done;
      frag_expect.push_back(f);
    end while (!done);
  endfunction

  // Random record length, biased toward short tails and block-filling sizes
  function automatic logic [LenW-1:0] pick_length();
    int unsigned hdr, room, k, r;
    hdr = cfg_recycle ? RecycleHdr : LegacyHdr;
    r = $urandom_range(0, 99);
    if (r < 35) return LenW'($urandom_range(0, 64));
    if (r < 50) return LenW'($urandom_range(0, 2000));
    if (r < 68) begin
      // land the block offset a few bytes short of the block end
      room = (BlockSize - blk_offset < hdr) ? BlockSize - hdr
                                            : BlockSize - blk_offset - hdr;
      k = $urandom_range(0, 12);
      return (room >= k) ? LenW'(room - k) : LenW'($urandom_range(0, 16));
    end
    if (r < 85) return LenW'($urandom_range(0, 40000));
    if (r < 95) return LenW'($urandom_range(0, 200000));
    if (r < 98) return LenW'($urandom_range(0, MaxRecordBytes));
    return LenW'($urandom_range(MaxRecordBytes, (1 << LenW) - 1));
  endfunction

  // Record transfer, then the layout update
  task automatic send_record(logic [LenW-1:0] len, logic [CrcW-1:0] crc);
    int unsigned gap;
    @(negedge clk_i);
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      rec_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rec_bus.valid         <= 1'b1;
    rec_bus.record_length <= len;
    rec_bus.record_crc    <= crc;
    do @(posedge clk_i); while (!rec_bus.ready);
    layout_record(len, crc);
  endtask

  // Drop the record valid and wait until all fragments have come
  task automatic drain();
    @(negedge clk_i);
    rec_bus.valid <= 1'b0;
    while (frag_expect.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write transfer
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == CfgRecycleMode) cfg_recycle = data[0];
    else if (idx == CfgLogNumber) cfg_lognum = data;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Output side: random stall before each transfer
  initial begin
    int unsigned stall;
    frag_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = sink_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        frag_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      frag_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!frag_bus.valid);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Fragment checker
  always @(posedge clk_i) begin
    frag_t want;
    if (rst_ni && frag_bus.valid && frag_bus.ready) begin
      if (frag_expect.size() == 0) begin
        $error("fragment transfer with nothing expected");
        mismatches++;
      end else begin
        want = frag_expect.pop_front();
        check_field("pad_bytes", 32'(want.pad), 32'(frag_bus.pad_bytes));
        check_field("fragment_type", 32'(want.ftype), 32'(frag_bus.fragment_type));
        check_field("payload_bytes", 32'(want.flen), 32'(frag_bus.payload_bytes));
        check_field("header_length", 32'(want.hdr), 32'(frag_bus.header_length));
        check_field("header_crc", want.crc, frag_bus.header_crc);
        check_field("header_log_number", want.lognum, frag_bus.header_log_number);
        check_field("last_fragment", 32'(want.last), 32'(frag_bus.last_fragment));
      end
    end
  end

  // Stimulus
  initial begin
    row_t        row;
    frag_t       typed_frag;
    int unsigned p, n;
    bit          mode;
    logic [31:0] lognum;

    rst_ni = 1'b0;
    cycles = 0;
    mismatches = 0;
    src_burst = 1'b0;
    sink_burst = 1'b0;
    blk_offset = 0;
    cfg_recycle = 1'b0;
    cfg_lognum = '0;
    rec_bus.valid = 1'b0;
    rec_bus.record_length = '0;
    rec_bus.record_crc = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;

    // kind, index, length, crc or data, typed, pad, type, frag len, hdr, log number
    dir_table = '{
      // empty record after reset
      '{RowRecord, '0, 0, 32'h0000_0000, 1, 0, TypeFull, 0, LegacyHdr, 0},
      '{RowRecord, '0, 1, 32'hFFFF_FFFF, 1, 0, TypeFull, 1, LegacyHdr, 0},
      // log number is not shown in legacy headers
      '{RowConfig, CfgLogNumber, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
      // leaves an 8-byte tail
      '{RowRecord, '0, 32738, 32'hA5A5_A5A5, 1, 0, TypeFull, 32738, LegacyHdr, 0},
      '{RowConfig, CfgRecycleMode, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0},
      // 8-byte tail too short for the larger header: padded
      '{RowRecord, '0, 5, 32'h1234_5678, 1, 8, TypeFull + RecycleBase, 5, RecycleHdr,
        32'hFFFF_FFFF},
      // leaves a tail of exactly one header
      '{RowRecord, '0, 32730, 32'h0F0F_0F0F, 1, 0, TypeFull + RecycleBase, 32730,
        RecycleHdr, 32'hFFFF_FFFF},
      // zero-length first fragment, then a zero-pad block change
      '{RowRecord, '0, 100, 32'h5555_5555, 0, 0, 0, 0, 0, 0},
      // oversized records saturate
      '{RowRecord, '0, 21'h1F_FFFF, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 1048576, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
      // writes to unused indexes are dropped
      '{RowConfig, CfgSpareIdx, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0},
      '{RowConfig, CfgTopIdx, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0},
      // only bit 0 of the mode write counts
      '{RowConfig, CfgRecycleMode, 0, 32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 32761, 32'h3C3C_3C3C, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 65536, 32'hC3C3_C3C3, 0, 0, 0, 0, 0, 0},
      '{RowConfig, CfgLogNumber, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 21'h0A_AAAA, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 21'h15_5555, 32'hA5A5_A5A5, 0, 0, 0, 0, 0, 0},
      '{RowConfig, CfgRecycleMode, 0, 32'h0000_0003, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 0, 32'h8000_0001, 0, 0, 0, 0, 0, 0},
      '{RowRecord, '0, 32757, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 0},
      '{RowConfig, CfgRecycleMode, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.kind == RowConfig) begin
        drain();
        write_reg(row.idx, row.word);
      end else begin
        send_record(row.len, row.word);
        if (row.typed) begin
          typed_frag = '{row.pad, row.ftype, row.flen, row.hdr, row.word, row.lognum, 1'b1};
          frag_expect[frag_expect.size() - 1] = typed_frag;
        end
      end
    end

    // Random phases, each with its own register setting
    for (p = 0; p < PhaseCount; p++) begin
      drain();
      mode = (p % 2 == 0);
      case (p % 3)
        0: lognum = $urandom();
        1: lognum = '1;
        default: lognum = '0;
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(CfgLogNumber, lognum);
        write_reg(CfgRecycleMode, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, mode});
      end else begin
        write_reg(CfgRecycleMode, {31'($urandom()), mode});
        write_reg(CfgLogNumber, lognum);
      end
      if ($urandom_range(0, 2) == 0) write_reg(CfgSpareIdx, $urandom());
      src_burst  = (p == 1) || ($urandom_range(0, 3) == 0);
      sink_burst = (p == 1) || ($urandom_range(0, 3) == 0);
      for (n = 0; n < PhaseItems; n++) begin
        send_record(pick_length(), $urandom());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
